// ===== rtl/ksrdc_pkg.sv =====
`default_nettype none

package ksrdc_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int COUNT_BITS_DEFAULT = 8;
    localparam int KEY_W              = 32;
    localparam int DISP_W             = 8;

    typedef enum logic {
        OP_PUSH   = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_STORED  = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_REMOVED = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic start;   // launch the probe at the top occupied cell
        logic commit;  // marked cells take their upper neighbor's entry
        logic wr_en;   // push writes the addressed cell
    } ctrl_t;

    // Probe token handed from a cell to the one below it.
    typedef struct packed {
        logic probe;
        logic hit;
    } link_t;

endpackage

`default_nettype wire

// ===== rtl/ksrdc_cell.sv =====
`default_nettype none

module ksrdc_cell #(
    parameter int IDX        = 0,
    parameter int IDX_W      = 4,
    parameter int COUNT_BITS = ksrdc_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ksrdc_pkg::ctrl_t               ctrl,
    input  wire logic [IDX_W-1:0]               start_idx,
    input  wire logic [IDX_W-1:0]               wr_idx,
    input  wire logic [ksrdc_pkg::KEY_W-1:0]    bus_key,
    input  wire ksrdc_pkg::link_t               up_link,
    input  wire logic [COUNT_BITS-1:0]          up_cnt,
    input  wire logic [ksrdc_pkg::KEY_W-1:0]    up_key,
    input  wire logic [COUNT_BITS-1:0]          up_count,
    output ksrdc_pkg::link_t                    down_link,
    output logic [COUNT_BITS-1:0]               down_cnt,
    output logic [ksrdc_pkg::KEY_W-1:0]         own_key,
    output logic [COUNT_BITS-1:0]               own_count
);

    logic [ksrdc_pkg::KEY_W-1:0] key_reg;
    logic [COUNT_BITS-1:0]       count_reg;
    logic                        probe_reg;
    logic                        probe_next;
    logic                        hit_reg;
    logic [COUNT_BITS-1:0]       cnt_reg;
    logic                        shift_reg;
    logic                        match;
    logic [COUNT_BITS-1:0]       up_count_inc;

    assign match        = (key_reg == bus_key);
    assign probe_next   = (ctrl.start && (start_idx == IDX_W'(IDX))) || up_link.probe;
    assign up_count_inc = (up_count == {COUNT_BITS{1'b1}}) ? up_count
                                                           : up_count + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg <= 1'b0;
            hit_reg   <= 1'b0;
            shift_reg <= 1'b0;
        end else begin
            probe_reg <= probe_next;
            if (ctrl.start) begin
                hit_reg <= 1'b0;
            end else if (up_link.probe) begin
                hit_reg <= up_link.hit;
            end
            // mark every visited cell down to and including the match
            if (ctrl.start) begin
                shift_reg <= 1'b0;
            end else if (probe_reg && !hit_reg) begin
                shift_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (up_link.probe) begin
            cnt_reg <= up_cnt;
        end
        if (ctrl.wr_en && (wr_idx == IDX_W'(IDX))) begin
            key_reg   <= bus_key;
            count_reg <= '0;
        end else if (ctrl.commit && shift_reg) begin
            key_reg   <= up_key;
            count_reg <= up_count_inc;
        end
    end

    assign down_link.probe = probe_reg;
    assign down_link.hit   = hit_reg | match;
    assign down_cnt        = hit_reg ? cnt_reg : count_reg;
    assign own_key         = key_reg;
    assign own_count       = count_reg;

endmodule

`default_nettype wire

// ===== rtl/keyed_stack_remove_displace_count_unit.sv =====
// Keyed stack with remove-by-key and displacement counting.
//
// Input channel (s_valid/s_ready): s_operation selects push or remove, s_key
// names the entry. Result channel (m_valid/m_ready): m_status, m_key_echo and
// m_displacements, exactly one result word per input word.
//
// The stack is a row of DEPTH cells. A push writes the cell at the fill level
// and its result is registered on the accepting edge, as is the result of a
// remove on an empty stack. Any other remove launches a probe at the top
// occupied cell; the probe walks down one cell per cycle, carrying the first
// match it meets, and the result word is registered as the probe leaves the
// bottom cell. A found key then passes through a commit state that shifts the
// entries above it down; one word is in flight at a time.
//
// Reset empties the stack at once; entry contents are left as they are.
// A stalled receiver holds the result word in the output register; the next
// input word is taken only once that register is free or being drained.
`default_nettype none

module keyed_stack_remove_displace_count_unit #(
    parameter int DEPTH      = ksrdc_pkg::DEPTH_DEFAULT,
    parameter int COUNT_BITS = ksrdc_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_operation,
    input  wire logic signed [ksrdc_pkg::KEY_W-1:0]    s_key,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [1:0]                                 m_status,
    output logic signed [ksrdc_pkg::KEY_W-1:0]         m_key_echo,
    output logic [ksrdc_pkg::DISP_W-1:0]               m_displacements
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    ksrdc_pkg::state_t state_reg, state_next;
    logic [FILL_W-1:0]           fill_reg;
    logic [ksrdc_pkg::KEY_W-1:0] key_reg;
    logic                        m_valid_reg;
    ksrdc_pkg::status_t          status_reg;
    logic [ksrdc_pkg::DISP_W-1:0] disp_reg;

    ksrdc_pkg::ctrl_t            ctrl;
    logic                        accept;
    logic                        is_push;
    logic                        is_full;
    logic                        is_empty;
    logic [IDX_W-1:0]            start_idx;
    logic [IDX_W-1:0]            wr_idx;
    logic [ksrdc_pkg::KEY_W-1:0] bus_key;
    logic [ksrdc_pkg::DISP_W-1:0] disp_found;

    ksrdc_pkg::link_t            links  [DEPTH+1];
    logic [COUNT_BITS-1:0]       cnts   [DEPTH+1];
    logic [ksrdc_pkg::KEY_W-1:0] keys   [DEPTH+1];
    logic [COUNT_BITS-1:0]       counts [DEPTH+1];

    assign accept    = s_valid && s_ready;
    assign is_push   = (s_operation == ksrdc_pkg::OP_PUSH);
    assign is_full   = (fill_reg == FILL_W'(DEPTH));
    assign is_empty  = (fill_reg == '0);
    assign start_idx = IDX_W'(fill_reg - 1'b1);
    assign wr_idx    = IDX_W'(fill_reg);
    // push writes from the port; the probe compares against the held key
    assign bus_key   = (state_reg == ksrdc_pkg::ST_IDLE) ? s_key : key_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ksrdc_pkg::ST_IDLE: begin
                if (accept && !is_push && !is_empty) begin
                    state_next = ksrdc_pkg::ST_SCAN;
                end
            end
            ksrdc_pkg::ST_SCAN: begin
                // probe leaving the bottom cell ends the search
                if (links[0].probe) begin
                    state_next = links[0].hit ? ksrdc_pkg::ST_COMMIT
                                              : ksrdc_pkg::ST_IDLE;
                end
            end
            ksrdc_pkg::ST_COMMIT: begin
                state_next = ksrdc_pkg::ST_IDLE;
            end
            default: begin
                state_next = ksrdc_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready     = 1'b0;
        ctrl.start  = 1'b0;
        ctrl.commit = 1'b0;
        ctrl.wr_en  = 1'b0;
        case (state_reg)
            ksrdc_pkg::ST_IDLE: begin
                s_ready    = !m_valid_reg || m_ready;
                ctrl.start = accept && !is_push && !is_empty;
                ctrl.wr_en = accept && is_push && !is_full;
            end
            ksrdc_pkg::ST_COMMIT: begin
                ctrl.commit = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ksrdc_pkg::ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (ctrl.wr_en) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (ctrl.commit) begin
                fill_reg <= fill_reg - 1'b1;
            end
            // raise the word when a result is ready, drop it on handshake
            if (accept && (is_push || is_empty)) begin
                m_valid_reg <= 1'b1;
            end else if ((state_reg == ksrdc_pkg::ST_SCAN) && links[0].probe) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload and held key
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg  <= s_key;
            disp_reg <= '0;
            if (is_push) begin
                status_reg <= is_full ? ksrdc_pkg::STAT_FULL : ksrdc_pkg::STAT_STORED;
            end else begin
                status_reg <= ksrdc_pkg::STAT_MISSING;
            end
        end else if ((state_reg == ksrdc_pkg::ST_SCAN) && links[0].probe) begin
            if (links[0].hit) begin
                status_reg <= ksrdc_pkg::STAT_REMOVED;
                disp_reg   <= disp_found;
            end else begin
                status_reg <= ksrdc_pkg::STAT_MISSING;
                disp_reg   <= '0;
            end
        end
    end

    // Low bits of the carried count, zero-extended for narrow counts
    generate
        if (COUNT_BITS >= ksrdc_pkg::DISP_W) begin : g_disp_trunc
            assign disp_found = cnts[0][ksrdc_pkg::DISP_W-1:0];
        end else begin : g_disp_ext
            assign disp_found = {{(ksrdc_pkg::DISP_W - COUNT_BITS){1'b0}}, cnts[0]};
        end
    endgenerate

    // Nothing above the top cell
    assign links[DEPTH]  = '0;
    assign cnts[DEPTH]   = '0;
    assign keys[DEPTH]   = '0;
    assign counts[DEPTH] = '0;

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            ksrdc_cell #(
                .IDX        (i),
                .IDX_W      (IDX_W),
                .COUNT_BITS (COUNT_BITS)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .start_idx (start_idx),
                .wr_idx    (wr_idx),
                .bus_key   (bus_key),
                .up_link   (links[i+1]),
                .up_cnt    (cnts[i+1]),
                .up_key    (keys[i+1]),
                .up_count  (counts[i+1]),
                .down_link (links[i]),
                .down_cnt  (cnts[i]),
                .own_key   (keys[i]),
                .own_count (counts[i])
            );
        end
    endgenerate

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_key_echo      = key_reg;
    assign m_displacements = disp_reg;

endmodule

`default_nettype wire

// ===== test/keyed_stack_remove_displace_count_checker.sv =====
`timescale 1ns / 100ps

module keyed_stack_remove_displace_count_checker #(
    parameter int DEPTH      = ksrdc_pkg::DEPTH_DEFAULT,
    parameter int COUNT_BITS = ksrdc_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic                            s_operation,
    input  wire logic [ksrdc_pkg::KEY_W-1:0]     s_key,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic [1:0]                      m_status,
    input  wire logic [ksrdc_pkg::KEY_W-1:0]     m_key_echo,
    input  wire logic [ksrdc_pkg::DISP_W-1:0]    m_displacements,
    output int                                   mismatches,
    output int                                   words_pending,
    output int                                   stored_seen,
    output int                                   full_seen,
    output int                                   removed_seen,
    output int                                   missing_seen,
    output int                                   deepest_displacement
);

    typedef struct packed {
        ksrdc_pkg::status_t                status;
        logic [ksrdc_pkg::KEY_W-1:0]       key;
        logic [ksrdc_pkg::DISP_W-1:0]      disp;
    } outcome_t;

    // Shadow copy of the stack, bottom entry at index 0.
    logic [ksrdc_pkg::KEY_W-1:0] shadow_keys[DEPTH];
    logic [COUNT_BITS-1:0]       shadow_counts[DEPTH];
    int                          shadow_fill;

    outcome_t expected_outcomes[$];
    int       errs;
    int       n_stored;
    int       n_full;
    int       n_removed;
    int       n_missing;
    int       peak_disp;

    initial begin
        mismatches           = 0;
        words_pending        = 0;
        stored_seen          = 0;
        full_seen            = 0;
        removed_seen         = 0;
        missing_seen         = 0;
        deepest_displacement = 0;
        errs                 = 0;
        n_stored             = 0;
        n_full               = 0;
        n_removed            = 0;
        n_missing            = 0;
        peak_disp            = 0;
        shadow_fill          = 0;
    end

    // Apply one request to the shadow stack and work out its result word.
    task automatic stack_apply(input ksrdc_pkg::op_t op,
                               input logic [ksrdc_pkg::KEY_W-1:0] key,
                               output outcome_t res);
        int hit;
        hit        = -1;
        res.key    = key;
        res.disp   = '0;
        res.status = ksrdc_pkg::STAT_MISSING;
        if (op == ksrdc_pkg::OP_PUSH) begin
            if (shadow_fill >= DEPTH) begin
                res.status = ksrdc_pkg::STAT_FULL;
            end else begin
                shadow_keys[shadow_fill]   = key;
                shadow_counts[shadow_fill] = '0;
                shadow_fill++;
                res.status = ksrdc_pkg::STAT_STORED;
            end
        end else begin
            // topmost match wins
            for (int i = shadow_fill - 1; i >= 0; i--) begin
                if (hit < 0 && shadow_keys[i] == key) hit = i;
            end
            if (hit >= 0) begin
                res.disp = ksrdc_pkg::DISP_W'(shadow_counts[hit]);
                for (int i = hit + 1; i < shadow_fill; i++) begin
                    shadow_keys[i-1]   = shadow_keys[i];
                    shadow_counts[i-1] = (&shadow_counts[i]) ? shadow_counts[i]
                                                             : shadow_counts[i] + 1'b1;
                end
                shadow_fill--;
                res.status = ksrdc_pkg::STAT_REMOVED;
            end
        end
    endtask

    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            shadow_fill = 0;
            expected_outcomes.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("unexpected result word: status %0d key %h disp %0d",
                           m_status, m_key_echo, m_displacements);
                    errs++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (m_status !== want.status) begin
                        $error("m_status: expected %0d, got %0d", want.status, m_status);
                        errs++;
                    end
                    if (m_key_echo !== want.key) begin
                        $error("m_key_echo: expected %h, got %h", want.key, m_key_echo);
                        errs++;
                    end
                    if (m_displacements !== want.disp) begin
                        $error("m_displacements: expected %0d, got %0d",
                               want.disp, m_displacements);
                        errs++;
                    end
                    case (want.status)
                        ksrdc_pkg::STAT_STORED:  n_stored++;
                        ksrdc_pkg::STAT_FULL:    n_full++;
                        ksrdc_pkg::STAT_REMOVED: n_removed++;
                        default:                 n_missing++;
                    endcase
                    if (want.status == ksrdc_pkg::STAT_REMOVED && int'(want.disp) > peak_disp)
                        peak_disp = int'(want.disp);
                end
            end
            if (s_valid && s_ready) begin
                stack_apply(ksrdc_pkg::op_t'(s_operation), s_key, want);
                expected_outcomes.push_back(want);
            end
        end
        mismatches           <= errs;
        words_pending        <= expected_outcomes.size();
        stored_seen          <= n_stored;
        full_seen            <= n_full;
        removed_seen         <= n_removed;
        missing_seen         <= n_missing;
        deepest_displacement <= peak_disp;
    end

endmodule

// ===== test/keyed_stack_remove_displace_count_unit_tb.sv =====
`timescale 1ns / 100ps

module keyed_stack_remove_displace_count_unit_tb;

    localparam int DEPTH          = ksrdc_pkg::DEPTH_DEFAULT;
    localparam int COUNT_BITS     = ksrdc_pkg::COUNT_BITS_DEFAULT;
    localparam int RANDOM_WORDS   = 1250;
    localparam int POOL_SIZE      = 12;
    localparam int IDLE_PCT       = 33;
    // a remove walks the whole occupied stack, so the drain wait scales with DEPTH
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                         aclk;
    logic                         aresetn         = 1'b0;
    logic                         s_valid         = 1'b0;
    logic                         s_ready;
    logic                         s_operation     = 1'b0;
    logic [ksrdc_pkg::KEY_W-1:0]  s_key           = '0;
    logic                         m_valid;
    logic                         m_ready         = 1'b0;
    logic [1:0]                   m_status;
    logic [ksrdc_pkg::KEY_W-1:0]  m_key_echo;
    logic [ksrdc_pkg::DISP_W-1:0] m_displacements;

    // High during the stretch where neither side idles.
    logic steady = 1'b0;

    int mismatches;
    int words_pending;
    int stored_seen;
    int full_seen;
    int removed_seen;
    int missing_seen;
    int deepest_displacement;
    int idle_cycles = 0;

    keyed_stack_remove_displace_count_unit #(
        .DEPTH      (DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_key           (s_key),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_key_echo      (m_key_echo),
        .m_displacements (m_displacements)
    );

    keyed_stack_remove_displace_count_checker #(
        .DEPTH      (DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_key                (s_key),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_key_echo           (m_key_echo),
        .m_displacements      (m_displacements),
        .mismatches           (mismatches),
        .words_pending        (words_pending),
        .stored_seen          (stored_seen),
        .full_seen            (full_seen),
        .removed_seen         (removed_seen),
        .missing_seen         (missing_seen),
        .deepest_displacement (deepest_displacement)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Stall the result channel about a third of the time, never while steady.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: end the run when no word moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word accepted for %0d cycles, %0d results outstanding",
                     idle_cycles, words_pending);
            $display("[keyed_stack_remove_displace_count_unit] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request word and hold it until the block takes it. A random
    // idle gap goes in front unless the steady stretch is running.
    task automatic send_word(input ksrdc_pkg::op_t op,
                             input logic [ksrdc_pkg::KEY_W-1:0] key);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_key       <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        logic [ksrdc_pkg::KEY_W-1:0] key_pool[POOL_SIZE];
        int                          push_pct;
        int                          roll;

        // Extremes of the key field first, the rest random per run.
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
        push_pct = 50;

        // Hold reset, then release it for good.
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        // Remove from an empty stack: nothing there to find.
        send_word(ksrdc_pkg::OP_REMOVE, key_pool[0]);
        // Fill the stack: key extremes, a duplicate of the largest signed key, then filler.
        send_word(ksrdc_pkg::OP_PUSH, key_pool[0]);
        send_word(ksrdc_pkg::OP_PUSH, key_pool[1]);
        send_word(ksrdc_pkg::OP_PUSH, key_pool[2]);
        send_word(ksrdc_pkg::OP_PUSH, key_pool[3]);
        send_word(ksrdc_pkg::OP_PUSH, key_pool[1]);
        for (int i = 5; i < DEPTH; i++) send_word(ksrdc_pkg::OP_PUSH, 32'h0000_1000 + i);
        // Push onto a full stack: dropped, nothing changes.
        send_word(ksrdc_pkg::OP_PUSH, 32'h5A5A_A5A5);
        // Remove a key that is absent while full.
        send_word(ksrdc_pkg::OP_REMOVE, 32'h5A5A_A5A5);
        // Duplicate: the upper copy goes and the entries above it gain one.
        send_word(ksrdc_pkg::OP_REMOVE, key_pool[1]);
        // Remove the bottom entry: every entry above it gains one.
        send_word(ksrdc_pkg::OP_REMOVE, key_pool[0]);
        // The lower duplicate, now bottom, carries the count of one displacement.
        send_word(ksrdc_pkg::OP_REMOVE, key_pool[1]);
        // Top entry, displaced by all three removes below it.
        send_word(ksrdc_pkg::OP_REMOVE, 32'h0000_1000 + DEPTH - 1);

        // Random part: phases that lean toward pushes, toward removes or neither,
        // so the stack swings between empty and full and the counts of long-lived
        // entries climb. A few removes carry fully random keys as noise.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 64 == 0) begin
                roll = $urandom_range(2);
                push_pct = (roll == 0) ? 15 : (roll == 1) ? 50 : 85;
            end
            if (n == 500) steady <= 1'b1;
            if (n == 750) steady <= 1'b0;
            if ($urandom_range(99) < 8)
                send_word(ksrdc_pkg::OP_REMOVE, $urandom());
            else if ($urandom_range(99) < push_pct)
                send_word(ksrdc_pkg::OP_PUSH, key_pool[$urandom_range(POOL_SIZE - 1)]);
            else
                send_word(ksrdc_pkg::OP_REMOVE, key_pool[$urandom_range(POOL_SIZE - 1)]);
        end
        s_valid <= 1'b0;
        // let the checker count the last accepted word
        @(posedge aclk);

        // Drain: wait for every result, then watch a while for stray words.
        while (words_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d stores, %0d pushes dropped on a full stack, %0d removes",
                 stored_seen, full_seen, removed_seen);
        $display("and %0d missing keys; deepest displacement seen %0d, %0d mismatches",
                 missing_seen, deepest_displacement, mismatches);
        if (mismatches == 0 && words_pending == 0) begin
            $display("[keyed_stack_remove_displace_count_unit] OK");
        end else begin
            $display("[keyed_stack_remove_displace_count_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ksrdc_pkg.sv
rtl/ksrdc_cell.sv
rtl/keyed_stack_remove_displace_count_unit.sv
test/keyed_stack_remove_displace_count_checker.sv
test/keyed_stack_remove_displace_count_unit_tb.sv
